[rtl/core/sip_pkg.sv]
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants for segment_intersection_point
// Default coordinate width and the control word carried down the pipeline.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int COORD_BITS_DEFAULT = 16;

  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } sip_ctl_t;

endpackage

[rtl/core/segment_intersection_point.sv]
// ----------------------------------------------------------------------------
// segment_intersection_point: exact crossing point of two line segments
// Hit test by cross products, crossing point by a chain of divider cells.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  input   | in_valid_i / in_ready_o  | a/b start/end x/y, COORD_BITS each
//  output  | out_valid_o / out_ready_i| hit_o, cross_x_o, cross_y_o
//
//  One segment pair per cycle while the output is not stalled;
//  the pipeline is six front stages plus one divider cell per quotient bit.
//  A stalled output word holds the whole pipeline; bubbles are not squeezed.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module segment_intersection_point
  import sip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]  a_start_x_i,
  input  logic signed [COORD_BITS-1:0]  a_start_y_i,
  input  logic signed [COORD_BITS-1:0]  a_end_x_i,
  input  logic signed [COORD_BITS-1:0]  a_end_y_i,
  input  logic signed [COORD_BITS-1:0]  b_start_x_i,
  input  logic signed [COORD_BITS-1:0]  b_start_y_i,
  input  logic signed [COORD_BITS-1:0]  b_end_x_i,
  input  logic signed [COORD_BITS-1:0]  b_end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic signed [COORD_BITS-1:0]  cross_x_o,
  output logic signed [COORD_BITS-1:0]  cross_y_o
);

  localparam int DW = 2 * COORD_BITS + 3;
  localparam int NW = 3 * COORD_BITS + 4;
  localparam int QB = COORD_BITS + 1;

  logic          en;
  sip_ctl_t      ctl   [QB+1];
  logic [DW-1:0] den   [QB+1];
  logic [NW-1:0] rem_x [QB+1];
  logic [NW-1:0] rem_y [QB+1];
  logic [QB-1:0] q_x   [QB+1];
  logic [QB-1:0] q_y   [QB+1];
  logic [QB-1:0] sx, sy;

  assign en         = !ctl[QB].valid || out_ready_i;
  assign in_ready_o = en;

  sip_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .ax0_i   (a_start_x_i),
    .ay0_i   (a_start_y_i),
    .ax1_i   (a_end_x_i),
    .ay1_i   (a_end_y_i),
    .bx0_i   (b_start_x_i),
    .by0_i   (b_start_y_i),
    .bx1_i   (b_end_x_i),
    .by1_i   (b_end_y_i),
    .ctl_o   (ctl[0]),
    .den_o   (den[0]),
    .rem_x_o (rem_x[0]),
    .rem_y_o (rem_y[0])
  );

  assign q_x[0] = '0;
  assign q_y[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    sip_div_cell #(.COORD_BITS(COORD_BITS), .BIT_POS(QB - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctl_i   (ctl[k]),
      .den_i   (den[k]),
      .rem_x_i (rem_x[k]),
      .rem_y_i (rem_y[k]),
      .q_x_i   (q_x[k]),
      .q_y_i   (q_y[k]),
      .ctl_o   (ctl[k+1]),
      .den_o   (den[k+1]),
      .rem_x_o (rem_x[k+1]),
      .rem_y_o (rem_y[k+1]),
      .q_x_o   (q_x[k+1]),
      .q_y_o   (q_y[k+1])
    );
  end

  // truncate toward zero: negate the magnitude quotient
  assign sx = ctl[QB].neg_x ? QB'(-q_x[QB]) : q_x[QB];
  assign sy = ctl[QB].neg_y ? QB'(-q_y[QB]) : q_y[QB];

  assign out_valid_o = ctl[QB].valid;
  assign hit_o       = ctl[QB].hit;
  assign cross_x_o   = ctl[QB].hit ? sx[COORD_BITS-1:0] : '0;
  assign cross_y_o   = ctl[QB].hit ? sy[COORD_BITS-1:0] : '0;

endmodule

[rtl/core/sip_front.sv]
// ----------------------------------------------------------------------------
// sip_front: cross products, hit test and crossing numerators
// Six register stages: differences, products, den/sn/tn, sign fold and hit,
// numerator products, numerator sums split into sign and magnitude.
// ----------------------------------------------------------------------------
module sip_front
  import sip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [COORD_BITS-1:0]  ax0_i,
  input  logic signed [COORD_BITS-1:0]  ay0_i,
  input  logic signed [COORD_BITS-1:0]  ax1_i,
  input  logic signed [COORD_BITS-1:0]  ay1_i,
  input  logic signed [COORD_BITS-1:0]  bx0_i,
  input  logic signed [COORD_BITS-1:0]  by0_i,
  input  logic signed [COORD_BITS-1:0]  bx1_i,
  input  logic signed [COORD_BITS-1:0]  by1_i,
  output sip_ctl_t                      ctl_o,
  output logic [2*COORD_BITS+2:0]       den_o,
  output logic [3*COORD_BITS+3:0]       rem_x_o,
  output logic [3*COORD_BITS+3:0]       rem_y_o
);

  localparam int DB = COORD_BITS + 1;
  localparam int PB = 2 * COORD_BITS + 2;
  localparam int DW = 2 * COORD_BITS + 3;
  localparam int NW = 3 * COORD_BITS + 4;
  localparam int C  = COORD_BITS;

  logic [6:1] vld_q;
  logic hit4_q, hit5_q, negx_q, negy_q;

  // stage 1
  logic signed [DB-1:0] sax1_q, say1_q, sbx1_q, sby1_q, wx1_q, wy1_q;
  logic signed [C-1:0]  ax1_q, ay1_q;
  // stage 2
  logic signed [PB-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DB-1:0] sax2_q, say2_q;
  logic signed [C-1:0]  ax2_q, ay2_q;
  // stage 3
  logic signed [DW-1:0] den3_q, sn3_q, tn3_q;
  logic signed [DB-1:0] sax3_q, say3_q;
  logic signed [C-1:0]  ax3_q, ay3_q;
  // stage 4
  logic signed [DW-1:0] den_d, sn_d, tn_d, den4_q, tn4_q;
  logic                 hit_d;
  logic signed [DB-1:0] sax4_q, say4_q;
  logic signed [C-1:0]  ax4_q, ay4_q;
  // stage 5
  logic signed [NW-1:0] mx0_q, mx1_q, my0_q, my1_q;
  logic signed [DW-1:0] den5_q;
  // stage 6
  logic signed [NW-1:0] nx_d, ny_d;
  logic [NW-1:0]        magx_q, magy_q;
  logic [DW-1:0]        den6_q;

  always_comb begin
    den_d = den3_q;
    sn_d  = sn3_q;
    tn_d  = tn3_q;
    if (den3_q < 0) begin
      den_d = -den3_q;
      sn_d  = -sn3_q;
      tn_d  = -tn3_q;
    end
    hit_d = (den_d != '0) && (sn_d >= 0) && (sn_d <= den_d) &&
            (tn_d >= 0) && (tn_d <= den_d);
  end

  assign nx_d = mx0_q + mx1_q;
  assign ny_d = my0_q + my1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sax1_q <= DB'(ax1_i) - DB'(ax0_i);
      say1_q <= DB'(ay1_i) - DB'(ay0_i);
      sbx1_q <= DB'(bx1_i) - DB'(bx0_i);
      sby1_q <= DB'(by1_i) - DB'(by0_i);
      wx1_q  <= DB'(ax0_i) - DB'(bx0_i);
      wy1_q  <= DB'(ay0_i) - DB'(by0_i);
      ax1_q  <= ax0_i;
      ay1_q  <= ay0_i;

      p0_q   <= PB'(sax1_q) * PB'(sby1_q);
      p1_q   <= PB'(sbx1_q) * PB'(say1_q);
      p2_q   <= PB'(sax1_q) * PB'(wy1_q);
      p3_q   <= PB'(say1_q) * PB'(wx1_q);
      p4_q   <= PB'(sbx1_q) * PB'(wy1_q);
      p5_q   <= PB'(sby1_q) * PB'(wx1_q);
      sax2_q <= sax1_q;
      say2_q <= say1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;

      den3_q <= DW'(p0_q) - DW'(p1_q);
      sn3_q  <= DW'(p2_q) - DW'(p3_q);
      tn3_q  <= DW'(p4_q) - DW'(p5_q);
      sax3_q <= sax2_q;
      say3_q <= say2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;

      den4_q <= den_d;
      tn4_q  <= tn_d;
      hit4_q <= hit_d;
      sax4_q <= sax3_q;
      say4_q <= say3_q;
      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;

      mx0_q  <= NW'(ax4_q) * NW'(den4_q);
      mx1_q  <= NW'(tn4_q) * NW'(sax4_q);
      my0_q  <= NW'(ay4_q) * NW'(den4_q);
      my1_q  <= NW'(tn4_q) * NW'(say4_q);
      den5_q <= den4_q;
      hit5_q <= hit4_q;

      negx_q <= nx_d < 0;
      negy_q <= ny_d < 0;
      magx_q <= (nx_d < 0) ? NW'(-nx_d) : NW'(nx_d);
      magy_q <= (ny_d < 0) ? NW'(-ny_d) : NW'(ny_d);
      den6_q <= den5_q;
    end
  end

  logic hit6_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit6_q <= hit5_q;
    end
  end

  assign ctl_o   = '{valid: vld_q[6], hit: hit6_q, neg_x: negx_q, neg_y: negy_q};
  assign den_o   = den6_q;
  assign rem_x_o = magx_q;
  assign rem_y_o = magy_q;

endmodule

[rtl/core/sip_div_cell.sv]
// ----------------------------------------------------------------------------
// sip_div_cell: one quotient bit of the crossing division
// Trial-subtracts the shifted denominator from both remainders and passes
// the word on to the next cell.
// ----------------------------------------------------------------------------
module sip_div_cell
  import sip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int BIT_POS    = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  sip_ctl_t                  ctl_i,
  input  logic [2*COORD_BITS+2:0]   den_i,
  input  logic [3*COORD_BITS+3:0]   rem_x_i,
  input  logic [3*COORD_BITS+3:0]   rem_y_i,
  input  logic [COORD_BITS:0]       q_x_i,
  input  logic [COORD_BITS:0]       q_y_i,
  output sip_ctl_t                  ctl_o,
  output logic [2*COORD_BITS+2:0]   den_o,
  output logic [3*COORD_BITS+3:0]   rem_x_o,
  output logic [3*COORD_BITS+3:0]   rem_y_o,
  output logic [COORD_BITS:0]       q_x_o,
  output logic [COORD_BITS:0]       q_y_o
);

  localparam int NW = 3 * COORD_BITS + 4;
  localparam int QB = COORD_BITS + 1;

  logic [NW-1:0] dsh;
  logic          ge_x, ge_y;
  logic          vld_q;
  logic [2:0]    flg_q;
  logic [2*COORD_BITS+2:0] den_q;
  logic [NW-1:0] rx_q, ry_q;
  logic [QB-1:0] qx_q, qy_q;

  assign dsh  = NW'(den_i) << BIT_POS;
  assign ge_x = rem_x_i >= dsh;
  assign ge_y = rem_y_i >= dsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flg_q <= {ctl_i.hit, ctl_i.neg_x, ctl_i.neg_y};
      den_q <= den_i;
      rx_q  <= ge_x ? rem_x_i - dsh : rem_x_i;
      ry_q  <= ge_y ? rem_y_i - dsh : rem_y_i;
      qx_q  <= q_x_i | (QB'(ge_x) << BIT_POS);
      qy_q  <= q_y_i | (QB'(ge_y) << BIT_POS);
    end
  end

  assign ctl_o   = '{valid: vld_q, hit: flg_q[2], neg_x: flg_q[1], neg_y: flg_q[0]};
  assign den_o   = den_q;
  assign rem_x_o = rx_q;
  assign rem_y_o = ry_q;
  assign q_x_o   = qx_q;
  assign q_y_o   = qy_q;

endmodule

[rtl/core/sip_checker.sv]
// ----------------------------------------------------------------------------
// sip_checker: port-level checks for segment_intersection_point
// Output word hold, stall back-pressure and zeroed misses.
// ----------------------------------------------------------------------------
module sip_checker
  import sip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          hit_o,
  input logic signed [COORD_BITS-1:0]  cross_x_o,
  input logic signed [COORD_BITS-1:0]  cross_y_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(hit_o) && $stable(cross_x_o) && $stable(cross_y_o))
    else $error("output word changed while stalled");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> cross_x_o == '0 && cross_y_o == '0)
    else $error("miss with nonzero crossing point");

endmodule

bind segment_intersection_point sip_checker #(.COORD_BITS(COORD_BITS)) u_sip_checker (.*);
